FILE: sv/rcf_pkg.sv
// Shared types and constants for the RGB 3x3 convolution filter.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package rcf_pkg;

    localparam int CFG_W        = 12;
    localparam int CFG_IDX_W    = 3;
    localparam int CH_W         = 8;
    localparam int PIX_W        = 3 * CH_W;
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W        = 13;
    // reciprocal of 9 in Q15, exact for sums up to 9 * 255
    localparam int RECIP9       = 3641;
    localparam int RECIP9_SH    = 15;

    typedef logic [PIX_W-1:0] rgb_t;

    typedef enum logic [1:0] {
        KM_SHARPEN = 2'd0,
        KM_BOX     = 2'd1,
        KM_GAUSS   = 2'd2,
        KM_EDGE    = 2'd3
    } kmode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_SEL_LEFT     = 3'd2,
        REG_SEL_TOP      = 3'd3,
        REG_SEL_RIGHT    = 3'd4,
        REG_SEL_BOTTOM   = 3'd5,
        REG_KERNEL_MODE  = 3'd6,
        REG_UNUSED       = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] image_width;
        logic [CFG_W-1:0] image_height;
        logic [CFG_W-1:0] sel_left;
        logic [CFG_W-1:0] sel_top;
        logic [CFG_W-1:0] sel_right;
        logic [CFG_W-1:0] sel_bottom;
        kmode_t           kernel_mode;
    } cfg_t;

    typedef struct packed {
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
        logic            drain;
    } in_item_t;

    typedef struct packed {
        logic [CH_W-1:0] red_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] blue_out;
        logic            frame_end;
    } out_item_t;

    // classified operation handed from the front to the back
    typedef struct packed {
        logic is_push;    // shift window with top/mid/bot column
        logic emit;       // produces a result
        logic filt;       // apply the kernel, else pass center or mid
        logic frame_end;
        rgb_t top;
        rgb_t mid;
        rgb_t bot;
    } q_item_t;

endpackage

`default_nettype wire

FILE: sv/rcf_front.sv
// Front end: input counters, line store read-modify-write and item classification.
// Depends on rcf_pkg; feeds rcf_queue.
`default_nettype none

module rcf_front #(
    parameter int MAX_WIDTH  = rcf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rcf_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire rcf_pkg::cfg_t              cfg,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire rcf_pkg::in_item_t          s_data,
    input  wire logic [rcf_pkg::QCNT_W-1:0] q_count,
    output logic                            q_push,
    output rcf_pkg::q_item_t                q_item
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int MW_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int CMP_W = ((MW_W > rcf_pkg::CFG_W) ? MW_W : rcf_pkg::CFG_W) + 2;
    localparam int ENT_W = 2 * rcf_pkg::PIX_W;

    // line store: older row in upper half, newer row in lower half
    logic [ENT_W-1:0] mem [MAX_WIDTH];
    logic [ENT_W-1:0] rd_data_reg;
    logic [COL_W-1:0] lw_addr_reg;
    logic [ENT_W-1:0] lw_data_reg;

    logic             clr_reg, clr_next;
    logic [COL_W-1:0] clr_addr_reg, clr_addr_next;

    logic [COL_W-1:0] in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [CMP_W-1:0] pend_reg, pend_next;

    logic                 op_valid_reg, op_push_reg, op_emit_reg, op_filt_reg;
    logic                 op_fe_reg, op_older_reg;
    logic [COL_W-1:0]     op_addr_reg;
    rcf_pkg::rgb_t        op_px_reg;

    logic [CMP_W-1:0] ew, eh, w_x, h_x;
    logic [CMP_W-1:0] ic_x, ir_x, oc_x, or_x;
    logic             accept, take, is_drain, push_emit, drain_live, out_adv;
    logic             border, in_sel, fe;
    logic [COL_W-1:0] rd_addr;
    logic             mem_we;
    logic [COL_W-1:0] mem_waddr;
    logic [ENT_W-1:0] mem_wdata, ent;
    rcf_pkg::rgb_t    older, newer;

    // effective image size
    always_comb begin
        w_x = CMP_W'(cfg.image_width);
        h_x = CMP_W'(cfg.image_height);
        if (w_x == '0) begin
            ew = CMP_W'(1);
        end else if (w_x > CMP_W'(MAX_WIDTH)) begin
            ew = CMP_W'(MAX_WIDTH);
        end else begin
            ew = w_x;
        end
        if (h_x == '0) begin
            eh = CMP_W'(1);
        end else if (h_x > CMP_W'(MAX_HEIGHT)) begin
            eh = CMP_W'(MAX_HEIGHT);
        end else begin
            eh = h_x;
        end
    end

    // hold input while clearing or while the queue may overflow
    assign s_ready = !clr_reg &&
        ((CMP_W'(q_count) + CMP_W'(op_valid_reg)) < CMP_W'(rcf_pkg::QUEUE_DEPTH));

    // classify the incoming item
    always_comb begin
        ic_x       = CMP_W'(in_col_reg);
        ir_x       = CMP_W'(in_row_reg);
        oc_x       = CMP_W'(out_col_reg);
        or_x       = CMP_W'(out_row_reg);
        accept     = s_valid && s_ready;
        is_drain   = s_data.drain;
        push_emit  = pend_reg >= ew + CMP_W'(1);
        drain_live = pend_reg != '0;
        take       = accept && (!is_drain || drain_live);
        out_adv    = accept && (is_drain ? drain_live : push_emit);
        rd_addr    = is_drain ? out_col_reg : in_col_reg;
        border     = (or_x == '0) || (oc_x == '0) ||
                     (or_x + CMP_W'(1) >= eh) || (oc_x + CMP_W'(1) >= ew);
        in_sel     = (oc_x >= CMP_W'(cfg.sel_left)) && (oc_x < CMP_W'(cfg.sel_right)) &&
                     (or_x >= CMP_W'(cfg.sel_top)) && (or_x < CMP_W'(cfg.sel_bottom));
        fe         = (or_x + CMP_W'(1) == eh) && (oc_x + CMP_W'(1) == ew);
    end

    // advance counters and pending count
    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        pend_next    = pend_reg;
        if (accept && !is_drain) begin
            if (ic_x + CMP_W'(1) >= ew) begin
                in_col_next = '0;
                in_row_next = (ir_x + CMP_W'(1) >= eh) ? '0 : ROW_W'(ir_x + CMP_W'(1));
            end else begin
                in_col_next = COL_W'(ic_x + CMP_W'(1));
            end
            pend_next = push_emit ? ew + CMP_W'(1) : pend_reg + CMP_W'(1);
        end else if (accept && drain_live) begin
            pend_next = pend_reg - CMP_W'(1);
        end
        if (out_adv) begin
            if (oc_x + CMP_W'(1) >= ew) begin
                out_col_next = '0;
                out_row_next = (or_x + CMP_W'(1) >= eh) ? '0 : ROW_W'(or_x + CMP_W'(1));
            end else begin
                out_col_next = COL_W'(oc_x + CMP_W'(1));
            end
        end
    end

    // clearing pass after reset
    always_comb begin
        clr_next      = clr_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_reg) begin
            clr_addr_next = clr_addr_reg + COL_W'(1);
            if (clr_addr_reg == COL_W'(MAX_WIDTH - 1)) begin
                clr_next = 1'b0;
            end
        end
    end

    // resolve entry with forwarding from the last write
    always_comb begin
        ent       = (lw_addr_reg == op_addr_reg) ? lw_data_reg : rd_data_reg;
        older     = ent[ENT_W-1:rcf_pkg::PIX_W];
        newer     = ent[rcf_pkg::PIX_W-1:0];
        mem_we    = clr_reg || (op_valid_reg && op_push_reg);
        mem_waddr = clr_reg ? clr_addr_reg : op_addr_reg;
        mem_wdata = clr_reg ? '0 : {newer, op_px_reg};
    end

    assign q_push           = op_valid_reg;
    assign q_item.is_push   = op_push_reg;
    assign q_item.emit      = op_emit_reg;
    assign q_item.filt      = op_filt_reg;
    assign q_item.frame_end = op_fe_reg;
    assign q_item.top       = older;
    assign q_item.mid       = (op_push_reg || !op_older_reg) ? newer : older;
    assign q_item.bot       = op_px_reg;

    // line store and its read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
            lw_addr_reg    <= mem_waddr;
            lw_data_reg    <= mem_wdata;
        end
        if (take) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // operation payload
    always_ff @(posedge aclk) begin
        if (take) begin
            op_push_reg  <= !is_drain;
            op_emit_reg  <= is_drain ? 1'b1 : push_emit;
            op_filt_reg  <= !is_drain && !border && in_sel;
            op_fe_reg    <= fe;
            op_older_reg <= pend_reg >= ew + CMP_W'(1);
            op_addr_reg  <= rd_addr;
            op_px_reg    <= {s_data.red_in, s_data.green_in, s_data.blue_in};
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            pend_reg     <= '0;
            op_valid_reg <= 1'b0;
        end else begin
            clr_reg      <= clr_next;
            clr_addr_reg <= clr_addr_next;
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            pend_reg     <= pend_next;
            op_valid_reg <= take;
        end
    end

endmodule

`default_nettype wire

FILE: sv/rcf_queue.sv
// Short FIFO of classified operations between front and back.
// Depends on rcf_pkg.
`default_nettype none

module rcf_queue (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        push,
    input  wire rcf_pkg::q_item_t            item_in,
    input  wire logic                        pop,
    output rcf_pkg::q_item_t                 item_out,
    output logic                             not_empty,
    output logic [rcf_pkg::QCNT_W-1:0]       count
);

    rcf_pkg::q_item_t             entry_reg [rcf_pkg::QUEUE_DEPTH];
    logic [rcf_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [rcf_pkg::QCNT_W-1:0]   cnt_reg, cnt_next;

    assign count     = cnt_reg;
    assign not_empty = cnt_reg != '0;
    assign item_out  = entry_reg[rd_ptr_reg];

    // advance pointers and fill level
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + rcf_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + rcf_pkg::QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + rcf_pkg::QCNT_W'(push) - rcf_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/rcf_back.sv
// Back end: 3x3 window, kernel sums, scaling, clamping and the output register.
// Depends on rcf_pkg; fed by rcf_queue.
`default_nettype none

module rcf_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire rcf_pkg::kmode_t    kernel_mode,
    input  wire logic               q_valid,
    input  wire rcf_pkg::q_item_t   q_item,
    output logic                    q_pop,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output rcf_pkg::out_item_t      m_data
);

    localparam int SUM_W = rcf_pkg::SUM_W;
    localparam int CH_W  = rcf_pkg::CH_W;
    localparam int PRD_W = 2 * (SUM_W - 1);

    rcf_pkg::rgb_t taps_reg [9];
    rcf_pkg::rgb_t taps_next [9];

    logic          w_valid_reg, w_filt_reg, w_fe_reg;
    rcf_pkg::rgb_t w_pass_reg;
    logic          s_valid_reg, s_filt_reg, s_fe_reg;
    rcf_pkg::rgb_t s_pass_reg;
    logic signed [SUM_W-1:0] s_sum_reg [3];
    logic          m_valid_reg;
    rcf_pkg::out_item_t m_data_reg;

    logic en_o, en_s, en_w;
    logic [SUM_W-1:0] cen_x [3], edg_x [3], cor_x [3];
    logic signed [SUM_W-1:0] sum_c [3];
    logic [PRD_W-1:0] prod [3];
    logic signed [SUM_W-1:0] scaled [3];
    logic [CH_W-1:0] res [3];
    rcf_pkg::rgb_t res_px;

    // pipeline enables
    assign en_o  = !m_valid_reg || m_ready;
    assign en_s  = !s_valid_reg || en_o;
    assign en_w  = !w_valid_reg || en_s;
    assign q_pop = q_valid && en_w;

    // shift window by one column on a push
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            taps_next[i] = taps_reg[i];
        end
        if (q_pop && q_item.is_push) begin
            for (int r = 0; r < 3; r++) begin
                taps_next[r*3]   = taps_reg[r*3+1];
                taps_next[r*3+1] = taps_reg[r*3+2];
            end
            taps_next[2] = q_item.top;
            taps_next[5] = q_item.mid;
            taps_next[8] = q_item.bot;
        end
    end

    // kernel sums per channel
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            cen_x[ch] = SUM_W'(taps_reg[4][8*(2-ch) +: 8]);
            edg_x[ch] = SUM_W'(taps_reg[1][8*(2-ch) +: 8]) + SUM_W'(taps_reg[3][8*(2-ch) +: 8])
                      + SUM_W'(taps_reg[5][8*(2-ch) +: 8]) + SUM_W'(taps_reg[7][8*(2-ch) +: 8]);
            cor_x[ch] = SUM_W'(taps_reg[0][8*(2-ch) +: 8]) + SUM_W'(taps_reg[2][8*(2-ch) +: 8])
                      + SUM_W'(taps_reg[6][8*(2-ch) +: 8]) + SUM_W'(taps_reg[8][8*(2-ch) +: 8]);
            unique case (kernel_mode)
                rcf_pkg::KM_SHARPEN: begin
                    sum_c[ch] = $signed((cen_x[ch] << 2) + cen_x[ch] - edg_x[ch]);
                end
                rcf_pkg::KM_BOX: begin
                    sum_c[ch] = $signed(cen_x[ch] + edg_x[ch] + cor_x[ch]);
                end
                rcf_pkg::KM_GAUSS: begin
                    sum_c[ch] = $signed((cen_x[ch] << 2) + (edg_x[ch] << 1) + cor_x[ch]);
                end
                rcf_pkg::KM_EDGE: begin
                    sum_c[ch] = $signed((cen_x[ch] << 3) - edg_x[ch] - cor_x[ch]);
                end
                default: begin
                    sum_c[ch] = '0;
                end
            endcase
        end
    end

    // scale and clamp to 0..255
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            prod[ch] = PRD_W'(s_sum_reg[ch][SUM_W-2:0]) * PRD_W'(rcf_pkg::RECIP9);
            unique case (kernel_mode)
                rcf_pkg::KM_BOX:   scaled[ch] = $signed(SUM_W'(prod[ch] >> rcf_pkg::RECIP9_SH));
                rcf_pkg::KM_GAUSS: scaled[ch] = s_sum_reg[ch] >>> 4;
                default:           scaled[ch] = s_sum_reg[ch];
            endcase
            if (scaled[ch] < 0) begin
                res[ch] = '0;
            end else if (scaled[ch] > $signed(SUM_W'(255))) begin
                res[ch] = '1;
            end else begin
                res[ch] = CH_W'(scaled[ch]);
            end
        end
        res_px = s_filt_reg ? {res[0], res[1], res[2]} : s_pass_reg;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // stage payloads
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            w_filt_reg <= q_item.filt;
            w_fe_reg   <= q_item.frame_end;
            w_pass_reg <= q_item.is_push ? taps_reg[5] : q_item.mid;
        end
        if (en_s) begin
            s_filt_reg <= w_filt_reg;
            s_fe_reg   <= w_fe_reg;
            s_pass_reg <= w_pass_reg;
            for (int ch = 0; ch < 3; ch++) begin
                s_sum_reg[ch] <= sum_c[ch];
            end
        end
        if (en_o) begin
            m_data_reg.red_out   <= res_px[23:16];
            m_data_reg.green_out <= res_px[15:8];
            m_data_reg.blue_out  <= res_px[7:0];
            m_data_reg.frame_end <= s_fe_reg;
        end
    end

    // control state and window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                taps_reg[i] <= '0;
            end
        end else begin
            if (en_w) begin
                w_valid_reg <= q_pop && q_item.emit;
            end
            if (en_s) begin
                s_valid_reg <= w_valid_reg;
            end
            if (en_o) begin
                m_valid_reg <= s_valid_reg;
            end
            for (int i = 0; i < 9; i++) begin
                taps_reg[i] <= taps_next[i];
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/rgb_conv3x3_kernel_filter.sv
// 3x3 RGB convolution filter: one pixel per clock while s_ready is high, set by at
// most one line store read and one write per item; results about one image row late.
// Path: front operation register, queue, back end window, sum and output registers.
// Reset: synchronous, active low; afterwards a clearing pass over all MAX_WIDTH line
// store entries zeroes them, with s_ready low and configuration writes still taken.
// Top level: configuration registers, front end, queue and back end.
`default_nettype none

module rgb_conv3x3_kernel_filter #(
    parameter int MAX_WIDTH  = rcf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rcf_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [rcf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rcf_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire rcf_pkg::in_item_t             s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output rcf_pkg::out_item_t                 m_data
);

    rcf_pkg::cfg_t cfg_reg, cfg_next;
    logic                         q_push, q_pop, q_not_empty;
    rcf_pkg::q_item_t             q_in, q_out;
    logic [rcf_pkg::QCNT_W-1:0]   q_count;

    assign cfg_ready = 1'b1;

    // decode register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (rcf_pkg::cfg_idx_t'(cfg_index))
                rcf_pkg::REG_IMAGE_WIDTH:  cfg_next.image_width  = cfg_data;
                rcf_pkg::REG_IMAGE_HEIGHT: cfg_next.image_height = cfg_data;
                rcf_pkg::REG_SEL_LEFT:     cfg_next.sel_left     = cfg_data;
                rcf_pkg::REG_SEL_TOP:      cfg_next.sel_top      = cfg_data;
                rcf_pkg::REG_SEL_RIGHT:    cfg_next.sel_right    = cfg_data;
                rcf_pkg::REG_SEL_BOTTOM:   cfg_next.sel_bottom   = cfg_data;
                rcf_pkg::REG_KERNEL_MODE:  cfg_next.kernel_mode  = rcf_pkg::kmode_t'(cfg_data[1:0]);
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width  <= rcf_pkg::CFG_W'(2048);
            cfg_reg.image_height <= rcf_pkg::CFG_W'(2048);
            cfg_reg.sel_left     <= '0;
            cfg_reg.sel_top      <= '0;
            cfg_reg.sel_right    <= rcf_pkg::CFG_W'(2048);
            cfg_reg.sel_bottom   <= rcf_pkg::CFG_W'(2048);
            cfg_reg.kernel_mode  <= rcf_pkg::KM_SHARPEN;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    rcf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_count (q_count),
        .q_push  (q_push),
        .q_item  (q_in)
    );

    rcf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .item_in   (q_in),
        .pop       (q_pop),
        .item_out  (q_out),
        .not_empty (q_not_empty),
        .count     (q_count)
    );

    rcf_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .kernel_mode (cfg_reg.kernel_mode),
        .q_valid     (q_not_empty),
        .q_item      (q_out),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

`default_nettype wire

FILE: sv/rcf_checker.sv
// Port-level checks for the 3x3 convolution filter, bound to the top level.
// Depends on rcf_pkg and rgb_conv3x3_kernel_filter.
`default_nettype none

module rcf_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire rcf_pkg::out_item_t m_data
);

    // hold a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // no input taken in the cycle after reset while the line store clears
    assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("input ready during line store clear");

    // no result right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // no result just after reset is released
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_valid)
        else $error("result without accepted item");

endmodule

bind rgb_conv3x3_kernel_filter rcf_checker u_rcf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the RGB 3x3 convolution filter.
// Depends on rcf_pkg and rgb_conv3x3_kernel_filter; predicts each pixel and compares.
`timescale 1ns / 1ps

module testbench;

    localparam int LW = rcf_pkg::DEF_MAX_WIDTH;
    localparam int LH = rcf_pkg::DEF_MAX_HEIGHT;
    localparam int CYCLE_LIMIT = 2000000;

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [rcf_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [rcf_pkg::CFG_W-1:0]     cfg_data;
    logic                          s_valid;
    logic                          s_ready;
    rcf_pkg::in_item_t             s_data;
    logic                          m_valid;
    logic                          m_ready;
    rcf_pkg::out_item_t            m_data;

    rgb_conv3x3_kernel_filter u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // predictor state
    logic [11:0]     img_w, img_h, sl, st, sr, sb;
    rcf_pkg::kmode_t kmode;
    rcf_pkg::rgb_t   row_old [LW];
    rcf_pkg::rgb_t   row_new [LW];
    rcf_pkg::rgb_t   win [9];
    int unsigned in_col, in_row, out_col, out_row, queued_px;

    rcf_pkg::out_item_t pixel_q [$];
    int          mismatches;
    int          cycles;
    bit          stall_free;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // guard against a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("rgb_conv3x3_kernel_filter regression: fail");
            $finish;
        end
    end

    function automatic int unsigned width_eff();
        if (img_w == 0) return 1;
        if (img_w > LW) return LW;
        return img_w;
    endfunction

    function automatic int unsigned height_eff();
        if (img_h == 0) return 1;
        if (img_h > LH) return LH;
        return img_h;
    endfunction

    task automatic step_pos(ref int unsigned col, ref int unsigned row);
        if (col + 1 >= width_eff()) begin
            col = 0;
            row = (row + 1 >= height_eff()) ? 0 : row + 1;
        end else begin
            col = col + 1;
        end
    endtask

    function automatic logic [7:0] convolve(int sh);
        int acc;
        int kw [9];
        acc = 0;
        case (kmode)
            rcf_pkg::KM_SHARPEN: kw = '{0, -1, 0, -1, 5, -1, 0, -1, 0};
            rcf_pkg::KM_BOX:     kw = '{1, 1, 1, 1, 1, 1, 1, 1, 1};
            rcf_pkg::KM_GAUSS:   kw = '{1, 2, 1, 2, 4, 2, 1, 2, 1};
            default:             kw = '{-1, -1, -1, -1, 8, -1, -1, -1, -1};
        endcase
        for (int i = 0; i < 9; i++) acc += kw[i] * int'(win[i][sh +: 8]);
        if (kmode == rcf_pkg::KM_BOX) acc = acc / 9;
        else if (kmode == rcf_pkg::KM_GAUSS) acc = acc / 16;
        if (acc < 0) acc = 0;
        if (acc > 255) acc = 255;
        return acc[7:0];
    endfunction

    task automatic queue_pixel(rcf_pkg::rgb_t px);
        rcf_pkg::out_item_t o;
        o.red_out   = px[23:16];
        o.green_out = px[15:8];
        o.blue_out  = px[7:0];
        o.frame_end = (out_row + 1 == height_eff()) && (out_col + 1 == width_eff());
        step_pos(out_col, out_row);
        pixel_q.push_back(o);
    endtask

    // predict the filter output for one accepted item
    task automatic predict_filter(rcf_pkg::in_item_t it);
        int unsigned w, h, c;
        rcf_pkg::rgb_t px, cv [3];
        bit edge_px, sel_px;
        w = width_eff();
        h = height_eff();
        if (it.drain) begin
            if (queued_px == 0) return;
            c = out_col < LW ? out_col : 0;
            px = (queued_px >= w + 1) ? row_old[c] : row_new[c];
            queued_px--;
            queue_pixel(px);
            return;
        end
        px = {it.red_in, it.green_in, it.blue_in};
        c = in_col < LW ? in_col : 0;
        cv[0] = row_old[c];
        cv[1] = row_new[c];
        cv[2] = px;
        for (int r = 0; r < 3; r++) begin
            win[r*3]   = win[r*3+1];
            win[r*3+1] = win[r*3+2];
            win[r*3+2] = cv[r];
        end
        row_old[c] = cv[1];
        row_new[c] = px;
        step_pos(in_col, in_row);
        queued_px++;
        if (queued_px < w + 2) return;
        queued_px = w + 1;
        edge_px = out_row == 0 || out_col == 0 || out_row + 1 >= h || out_col + 1 >= w;
        sel_px  = out_col >= sl && out_col < sr && out_row >= st && out_row < sb;
        if (edge_px || !sel_px) queue_pixel(win[4]);
        else queue_pixel({convolve(16), convolve(8), convolve(0)});
    endtask

    // drop valid for a random gap
    task automatic wait_idle_gap();
        if (!stall_free && $urandom_range(99) < 37) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    // send one item on the pixel channel; valid stays up for a following item
    task automatic send_item(rcf_pkg::in_item_t it);
        wait_idle_gap();
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        predict_filter(it);
    endtask

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        rcf_pkg::in_item_t it;
        it = '{red_in: r, green_in: g, blue_in: b, drain: 1'b0};
        send_item(it);
    endtask

    task automatic send_drain();
        rcf_pkg::in_item_t it;
        it = '{red_in: 8'($urandom), green_in: 8'($urandom), blue_in: 8'($urandom),
               drain: 1'b1};
        send_item(it);
    endtask

    // write one register; valid stays up for a following write
    task automatic write_reg(rcf_pkg::cfg_idx_t idx, logic [11:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            rcf_pkg::REG_IMAGE_WIDTH:  img_w = val;
            rcf_pkg::REG_IMAGE_HEIGHT: img_h = val;
            rcf_pkg::REG_SEL_LEFT:     sl = val;
            rcf_pkg::REG_SEL_TOP:      st = val;
            rcf_pkg::REG_SEL_RIGHT:    sr = val;
            rcf_pkg::REG_SEL_BOTTOM:   sb = val;
            rcf_pkg::REG_KERNEL_MODE:  kmode = rcf_pkg::kmode_t'(val[1:0]);
            default: ;
        endcase
    endtask

    // hold until all predicted pixels are out, then let the pipe settle
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic set_frame(int w, int h, int l, int t, int r, int b, rcf_pkg::kmode_t m);
        write_reg(rcf_pkg::REG_IMAGE_WIDTH, 12'(w));
        write_reg(rcf_pkg::REG_IMAGE_HEIGHT, 12'(h));
        write_reg(rcf_pkg::REG_SEL_LEFT, 12'(l));
        write_reg(rcf_pkg::REG_SEL_TOP, 12'(t));
        write_reg(rcf_pkg::REG_SEL_RIGHT, 12'(r));
        write_reg(rcf_pkg::REG_SEL_BOTTOM, 12'(b));
        write_reg(rcf_pkg::REG_KERNEL_MODE, 12'(m));
        cfg_valid <= 1'b0;
    endtask

    // one frame of random pixels, or of random saturating ones, followed by a full flush
    task automatic run_frame(int w, int h, bit extremes);
        for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
                if (extremes) begin
                    if ($urandom_range(1)) send_pixel(8'hff, 8'h00, 8'hff);
                    else send_pixel(8'h00, 8'hff, 8'h00);
                end else begin
                    send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
                end
            end
        end
        repeat (w + 2) send_drain();
    endtask

    // directed: every kernel on saturating pixels; size and selection corners are in test_odd_sizes
    task automatic test_kernels();
        for (int m = 0; m < 4; m++) begin
            set_frame(4, 4, 0, 0, 4, 4, rcf_pkg::kmode_t'(m));
            run_frame(4, 4, 1'b1);
            wait_drained();
        end
    endtask

    task automatic test_odd_sizes();
        // empty and inverted selections, degenerate sizes
        set_frame(1, 1, 0, 0, 0, 0, rcf_pkg::KM_EDGE);
        run_frame(1, 3, 1'b0);
        wait_drained();
        set_frame(5, 3, 3, 2, 1, 1, rcf_pkg::KM_SHARPEN);
        run_frame(5, 3, 1'b0);
        wait_drained();
        set_frame(0, 0, 0, 0, 4095, 4095, rcf_pkg::KM_BOX);
        run_frame(1, 2, 1'b0);
        wait_drained();
        // early drain with nothing pending and in mid image
        set_frame(4, 3, 1, 1, 3, 2, rcf_pkg::KM_GAUSS);
        send_drain();
        send_pixel(8'd1, 8'd2, 8'd3);
        send_drain();
        run_frame(4, 3, 1'b0);
        wait_drained();
    endtask

    task automatic test_random_frames();
        int sent, w, h;
        sent = 0;
        while (sent < 450) begin
            w = $urandom_range(3, 9);
            h = $urandom_range(3, 6);
            stall_free = ($urandom_range(4) == 0);
            set_frame(w, h, $urandom_range(0, w), $urandom_range(0, h),
                      $urandom_range(0, w + 1), $urandom_range(0, h + 1),
                      rcf_pkg::kmode_t'($urandom_range(3)));
            run_frame(w, h, 1'b0);
            wait_drained();
            sent += w * h + w + 2;
        end
        stall_free = 1'b0;
    endtask

    // result side: random back-pressure and compare against the prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pixel_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected pixel %h", m_data);
                end else if (m_data !== pixel_q[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pixel mismatch: expected %h got %h", pixel_q[0], m_data);
                    void'(pixel_q.pop_front());
                end else begin
                    void'(pixel_q.pop_front());
                end
            end
            m_ready <= stall_free || ($urandom_range(99) >= 37);
        end
    end

    initial begin
        cycles = 0;
        mismatches = 0;
        stall_free = 1'b0;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_data = '0;
        img_w = 12'd2048; img_h = 12'd2048;
        sl = 12'd0; st = 12'd0; sr = 12'd2048; sb = 12'd2048;
        kmode = rcf_pkg::KM_SHARPEN;
        for (int i = 0; i < LW; i++) begin
            row_old[i] = '0;
            row_new[i] = '0;
        end
        for (int i = 0; i < 9; i++) win[i] = '0;
        in_col = 0; in_row = 0; out_col = 0; out_row = 0; queued_px = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_kernels();
        test_odd_sizes();
        test_random_frames();
        wait_drained();
        if (mismatches == 0 && pixel_q.size() == 0)
            $display("rgb_conv3x3_kernel_filter regression: pass");
        else
            $display("rgb_conv3x3_kernel_filter regression: fail");
        $finish;
    end
endmodule

FILE: filelist.f
sv/rcf_pkg.sv
sv/rcf_front.sv
sv/rcf_queue.sv
sv/rcf_back.sv
sv/rgb_conv3x3_kernel_filter.sv
sv/rcf_checker.sv
tb/sv/testbench.sv
